@@ rtl/spce_pkg.sv @@
// Shared types, constants and helpers for the servo pulse command encoder.
package spce_pkg;

  typedef enum logic {
    OP_SET    = 1'b0,
    OP_RESEND = 1'b1
  } op_t;

  localparam logic [2:0] REG_SERVO  = 3'd0;
  localparam logic [2:0] REG_OFFSET = 3'd1;
  localparam logic [2:0] REG_LOWEST = 3'd2;
  localparam logic [2:0] REG_HIGHEST = 3'd3;
  localparam logic [2:0] REG_REVERSE = 3'd4;

  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_BANG = 8'h21;
  localparam logic [7:0] CH_P    = 8'h50;
  localparam logic [7:0] CH_T    = 8'h54;
  localparam logic [7:0] CH_ZERO = 8'h30;

  localparam logic [3:0] IDX_HASH = 4'd0;
  localparam logic [3:0] IDX_P    = 4'd4;
  localparam logic [3:0] IDX_T    = 4'd9;
  localparam logic [3:0] LAST_IDX = 4'd14;

  localparam logic [13:0] TIME_MAX = 14'd9999;

  // pulse*1e4 = 15e6 + a*1667 + off*1e4; the 15e6 and off terms are folded in after
  // the divide. Bias of 5500*1e4 keeps the dividend positive, 5000 rounds.
  localparam logic signed [27:0] ANG_GAIN = 28'sd1667;
  localparam logic signed [27:0] DIV_BIAS = 28'sd55005000;
  // floor(v/10000) = (v*RECIP) >> 40, exact for v < 2^27
  localparam logic [26:0] RECIP      = 27'd109951163;
  localparam logic signed [15:0] Q_SHIFT = 16'sd4000;
  localparam logic signed [15:0] PULSE_MIN = 16'sd500;
  localparam logic signed [15:0] PULSE_MAX = 16'sd2500;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  typedef struct packed {
    logic signed [10:0] pulse_offset;
    logic signed [15:0] lowest_angle;
    logic signed [15:0] highest_angle;
    logic               reverse_sense;
  } cfg_t;

  typedef struct packed {
    logic [11:0]        pulse;
    logic signed [15:0] angle;
    logic [13:0]        mtime;
  } cmd_t;

  // place value of the digit printed at frame position idx
  function automatic logic [9:0] digit_weight(input logic [3:0] idx);
    logic [9:0] w;
    case (idx)
      4'd1:  w = 10'd100;
      4'd2:  w = 10'd10;
      4'd5:  w = 10'd1000;
      4'd6:  w = 10'd100;
      4'd7:  w = 10'd10;
      4'd10: w = 10'd1000;
      4'd11: w = 10'd100;
      4'd12: w = 10'd10;
      default: w = 10'd1;
    endcase
    return w;
  endfunction

endpackage

@@ rtl/spce_front.sv @@
// Front end: accepts commands, clamps the angle and computes the pulse width.
module spce_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [31:0]        s_tdata,   // angle_cd[15:0], move_time[31:16]
  input  logic               s_tuser,   // opcode
  input  spce_pkg::cfg_t     cfg,
  output logic               push_valid,
  input  logic               push_ready,
  output spce_pkg::cmd_t     push_data
);

  logic signed [15:0] held_angle;
  logic signed [15:0] angle_in, a_clamp, a_rev, a_sel;
  logic [15:0]        mtime_in;
  logic [13:0]        mtime_sat;
  logic               adv, take;

  logic               v1, v2, v3;
  logic signed [15:0] a1, a2, a3;
  logic [13:0]        t1, t2, t3;
  logic signed [10:0] off1, off2, off3;
  logic [26:0]        div2;
  logic [13:0]        q3;

  logic signed [27:0] a1_ext, sum1;
  logic [53:0]        prod2;
  logic signed [15:0] p_raw;
  logic [11:0]        p_clamp;

  assign angle_in = s_tdata[15:0];
  assign mtime_in = s_tdata[31:16];

  always_comb begin
    a_clamp = angle_in;
    if (a_clamp < cfg.lowest_angle) a_clamp = cfg.lowest_angle;
    if (a_clamp > cfg.highest_angle) a_clamp = cfg.highest_angle;
    a_rev = a_clamp;
    if (cfg.reverse_sense) begin
      a_rev = (a_clamp == 16'sh8000) ? 16'sh7fff : -a_clamp;
    end
    a_sel = (spce_pkg::op_t'(s_tuser) == spce_pkg::OP_SET) ? a_rev : held_angle;
    mtime_sat = (mtime_in > 16'(spce_pkg::TIME_MAX)) ? spce_pkg::TIME_MAX : mtime_in[13:0];
  end

  assign adv      = !v3 || push_ready;
  assign s_tready = adv;
  assign take     = s_tvalid && adv;

  assign a1_ext = 28'(a1);
  assign sum1   = a1_ext * spce_pkg::ANG_GAIN + spce_pkg::DIV_BIAS;
  assign prod2  = 54'(div2) * 54'(spce_pkg::RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      held_angle <= '0;
    end else begin
      if (take) held_angle <= a_sel;
      if (adv) begin
        v1 <= s_tvalid;
        v2 <= v1;
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a1   <= a_sel;
      t1   <= mtime_sat;
      off1 <= cfg.pulse_offset;
      a2   <= a1;
      t2   <= t1;
      off2 <= off1;
      div2 <= sum1[26:0];
      a3   <= a2;
      t3   <= t2;
      off3 <= off2;
      q3   <= prod2[53:40];
    end
  end

  always_comb begin
    p_raw = $signed({2'b00, q3}) - spce_pkg::Q_SHIFT + 16'(off3);
    if (p_raw < spce_pkg::PULSE_MIN) p_clamp = 12'(spce_pkg::PULSE_MIN);
    else if (p_raw > spce_pkg::PULSE_MAX) p_clamp = 12'(spce_pkg::PULSE_MAX);
    else p_clamp = p_raw[11:0];
  end

  assign push_valid      = v3;
  assign push_data.pulse = p_clamp;
  assign push_data.angle = a3;
  assign push_data.mtime = t3;

endmodule

@@ rtl/spce_queue.sv @@
// Small command queue between the front and back ends.
module spce_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  spce_pkg::cmd_t push_data,
  output logic           pop_valid,
  input  logic           pop,
  output spce_pkg::cmd_t pop_data
);

  spce_pkg::cmd_t entries [spce_pkg::QDEPTH];
  logic [spce_pkg::QAW-1:0] wptr, rptr;
  logic [spce_pkg::QAW:0]   count;
  logic                     do_push, do_pop;

  assign push_ready = count != (spce_pkg::QAW+1)'(spce_pkg::QDEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = entries[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= wptr + 1'b1;
      if (do_pop) rptr <= rptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wptr] <= push_data;
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= (spce_pkg::QAW+1)'(spce_pkg::QDEPTH))
    else $error("queue count beyond depth");
  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    count == '0 |-> wptr == rptr)
    else $error("empty queue with unequal pointers");

endmodule

@@ rtl/spce_back.sv @@
// Back end: prints one command as a 15-byte ASCII frame, one byte per word.
module spce_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  spce_pkg::cmd_t q_data,
  output logic           pop,
  input  logic [7:0]     servo_number,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [39:0]    m_tdata,   // char_byte[7:0], pulse[19:8], applied_angle[35:20], zero pad
  output logic           m_tlast    // last
);

  typedef enum logic [1:0] {
    BK_IDLE = 2'b01,
    BK_RUN  = 2'b10
  } bk_state_t;

  bk_state_t      state;
  logic [3:0]     idx;
  spce_pkg::cmd_t cur;
  logic [13:0]    rem, rem_next;
  logic [9:0]     w;
  logic [3:0]     d;
  logic [7:0]     ch;
  logic           emit, last_char;

  assign emit      = (state == BK_RUN) && (!m_tvalid || m_tready);
  assign last_char = idx == spce_pkg::LAST_IDX;
  assign pop       = q_valid && ((state == BK_IDLE) || (emit && last_char));

  // leading digit by parallel compares against multiples of the place value
  always_comb begin
    w = spce_pkg::digit_weight(idx);
    d = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (rem >= 14'(k) * 14'(w)) d = 4'(k);
    end
    case (idx)
      spce_pkg::IDX_HASH: begin
        ch = spce_pkg::CH_HASH;
        rem_next = 14'(servo_number);
      end
      spce_pkg::IDX_P: begin
        ch = spce_pkg::CH_P;
        rem_next = 14'(cur.pulse);
      end
      spce_pkg::IDX_T: begin
        ch = spce_pkg::CH_T;
        rem_next = cur.mtime;
      end
      spce_pkg::LAST_IDX: begin
        ch = spce_pkg::CH_BANG;
        rem_next = rem;
      end
      default: begin
        ch = spce_pkg::CH_ZERO + 8'(d);
        rem_next = rem - 14'(d) * 14'(w);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BK_IDLE;
      idx      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (emit) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        BK_IDLE: begin
          if (pop) begin
            state <= BK_RUN;
            idx   <= '0;
          end
        end
        BK_RUN: begin
          if (emit) begin
            if (last_char) begin
              idx <= '0;
              if (!pop) state <= BK_IDLE;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        default: state <= BK_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= q_data;
    if (emit) begin
      rem     <= rem_next;
      m_tdata <= {4'b0000, cur.angle, cur.pulse, ch};
      m_tlast <= last_char;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx <= spce_pkg::LAST_IDX)
    else $error("frame index out of range");
  a_last_bang: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[7:0] == spce_pkg::CH_BANG)
    else $error("frame end is not the closing mark");
  a_mid_frame: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> state == BK_RUN)
    else $error("back end left frame early");

endmodule

@@ rtl/servo_pulse_command_encoder_core.sv @@
// A command word passes the front-end pipeline, the queue and the back-end output
// register before the first byte of its frame is valid. The back end prints 15-byte frames
// at one byte per cycle while m_tready is high; the front end and a 4-entry queue take new
// commands meanwhile. Reset (synchronous, rst high): pipelines and queue empty, registers
// to defaults, held angle 0.
module servo_pulse_command_encoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // angle_cd[15:0], move_time[31:16]
  input  logic        s_tuser,   // opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // char_byte[7:0], pulse[19:8], applied_angle[35:20], zero pad
  output logic        m_tlast,   // last
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]         servo_number;
  logic signed [10:0] pulse_offset;
  logic signed [15:0] lowest_angle, highest_angle;
  logic               reverse_sense;
  logic               wr_en;
  spce_pkg::cfg_t     cfg;

  logic               push_valid, push_ready, q_valid, pop;
  spce_pkg::cmd_t     push_data, q_data;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      servo_number  <= '0;
      pulse_offset  <= '0;
      lowest_angle  <= -16'sd6000;
      highest_angle <= 16'sd6000;
      reverse_sense <= 1'b0;
    end else if (wr_en) begin
      case (paddr[4:2])
        spce_pkg::REG_SERVO:   servo_number  <= pwdata[7:0];
        spce_pkg::REG_OFFSET:  pulse_offset  <= pwdata[10:0];
        spce_pkg::REG_LOWEST:  lowest_angle  <= pwdata[15:0];
        spce_pkg::REG_HIGHEST: highest_angle <= pwdata[15:0];
        spce_pkg::REG_REVERSE: reverse_sense <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      spce_pkg::REG_SERVO:   prdata = 32'(servo_number);
      spce_pkg::REG_OFFSET:  prdata = 32'(pulse_offset);
      spce_pkg::REG_LOWEST:  prdata = 32'(lowest_angle);
      spce_pkg::REG_HIGHEST: prdata = 32'(highest_angle);
      spce_pkg::REG_REVERSE: prdata = 32'(reverse_sense);
      default:               prdata = '0;
    endcase
  end

  assign cfg.pulse_offset  = pulse_offset;
  assign cfg.lowest_angle  = lowest_angle;
  assign cfg.highest_angle = highest_angle;
  assign cfg.reverse_sense = reverse_sense;

  spce_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .cfg        (cfg),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  spce_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop        (pop),
    .pop_data   (q_data)
  );

  spce_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .pop          (pop),
    .servo_number (servo_number),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast)
  );

endmodule
